// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

    localparam int unsigned LenW = 64;
    localparam int unsigned KeyW = 32;

    localparam logic [7:0] FinBit     = 8'h80;
    localparam logic [7:0] Rsv1Bit    = 8'h40;
    localparam logic [7:0] Rsv2Bit    = 8'h20;
    localparam logic [7:0] Rsv3Bit    = 8'h10;
    localparam logic [7:0] OpcodeMask = 8'h0F;
    localparam logic [7:0] LenMask    = 8'h7F;
    localparam logic [6:0] LenCode16  = 7'd126;
    localparam logic [6:0] LenCode64  = 7'd127;

    localparam logic [3:0] ExtBytes16 = 4'd2;
    localparam logic [3:0] ExtBytes64 = 4'd8;
    localparam logic [3:0] KeyBytes   = 4'd4;

    localparam logic KindHeader  = 1'b0;
    localparam logic KindPayload = 1'b1;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD
    } t_phase;

    typedef struct packed {
        logic            kind;
        logic            fin;
        logic            rsv1;
        logic            rsv2;
        logic            rsv3;
        logic [3:0]      opcode;
        logic            masked;
        logic [LenW-1:0] payload_length;
        logic [KeyW-1:0] mask_key;
        logic [7:0]      payload_byte;
        logic            last;
    } t_result;

endpackage

// ===== rtl/wsd_parser.sv =====
module wsd_parser
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase          r_phase, n_phase;
    logic [3:0]      r_cnt, n_cnt;
    logic            r_ext8, n_ext8;
    logic [7:0]      r_flags, n_flags;
    logic            r_mask, n_mask;
    logic [LenW-1:0] r_len, n_len;
    logic [KeyW-1:0] r_key, n_key;
    logic [LenW-1:0] r_rem, n_rem;
    logic [1:0]      r_kidx, n_kidx;

    logic [6:0] len_code;
    logic [3:0] cnt_inc;
    logic [3:0] ext_bytes;
    logic       ext_done;
    logic       key_done;
    logic       len_zero;
    logic       rem_last;
    logic [7:0] key_byte;

    assign len_code  = i_byte[6:0] & LenMask[6:0];
    assign cnt_inc   = r_cnt + 4'd1;
    assign ext_bytes = r_ext8 ? ExtBytes64 : ExtBytes16;
    assign ext_done  = (cnt_inc >= ext_bytes);
    assign key_done  = (cnt_inc >= KeyBytes);
    assign rem_last  = (r_rem[LenW-1:1] == '0);
    assign len_zero  = (n_len == '0);

    always_comb begin
        unique case (r_kidx)
            2'd0: key_byte = r_key[31:24];
            2'd1: key_byte = r_key[23:16];
            2'd2: key_byte = r_key[15:8];
            2'd3: key_byte = r_key[7:0];
            default: key_byte = r_key[7:0];
        endcase
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            unique case (r_phase)
                PH_FIRST: n_phase = PH_SECOND;
                PH_SECOND: begin
                    if (len_code == LenCode16 || len_code == LenCode64) begin
                        n_phase = PH_EXTLEN;
                    end else if (i_byte[7]) begin
                        n_phase = PH_KEY;
                    end else begin
                        n_phase = len_zero ? PH_FIRST : PH_PAYLOAD;
                    end
                end
                PH_EXTLEN: begin
                    if (ext_done) begin
                        if (r_mask) begin
                            n_phase = PH_KEY;
                        end else begin
                            n_phase = len_zero ? PH_FIRST : PH_PAYLOAD;
                        end
                    end
                end
                PH_KEY: begin
                    if (key_done) begin
                        n_phase = len_zero ? PH_FIRST : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (rem_last) begin
                        n_phase = PH_FIRST;
                    end
                end
                default: n_phase = PH_FIRST;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_cnt       = r_cnt;
        n_ext8      = r_ext8;
        n_flags     = r_flags;
        n_mask      = r_mask;
        n_len       = r_len;
        n_key       = r_key;
        n_rem       = r_rem;
        n_kidx      = r_kidx;
        o_res_valid = 1'b0;
        o_res.kind         = KindHeader;
        o_res.payload_byte = 8'd0;
        o_res.last         = 1'b0;
        if (i_step) begin
            unique case (r_phase)
                PH_FIRST: begin
                    n_flags = i_byte;
                    n_mask  = 1'b0;
                    n_len   = '0;
                    n_key   = '0;
                    n_cnt   = 4'd0;
                end
                PH_SECOND: begin
                    n_mask = i_byte[7];
                    n_cnt  = 4'd0;
                    if (len_code == LenCode16 || len_code == LenCode64) begin
                        n_ext8 = (len_code == LenCode64);
                        n_len  = '0;
                    end else begin
                        n_len = LenW'(len_code);
                        o_res_valid = !i_byte[7];
                    end
                end
                PH_EXTLEN: begin
                    n_len = {r_len[LenW-9:0], i_byte};
                    n_cnt = ext_done ? 4'd0 : cnt_inc;
                    o_res_valid = ext_done && !r_mask;
                end
                PH_KEY: begin
                    n_key = {r_key[KeyW-9:0], i_byte};
                    n_cnt = cnt_inc;
                    o_res_valid = key_done;
                end
                PH_PAYLOAD: begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = KindPayload;
                    o_res.payload_byte = r_mask ? (i_byte ^ key_byte) : i_byte;
                    o_res.last         = rem_last;
                    n_kidx             = r_kidx + 2'd1;
                    n_rem              = rem_last ? '0 : r_rem - LenW'(1);
                end
                default: begin
                    n_cnt   = 4'd0;
                    n_ext8  = 1'b0;
                    n_flags = '0;
                    n_mask  = 1'b0;
                    n_len   = '0;
                    n_key   = '0;
                    n_rem   = '0;
                    n_kidx  = 2'd0;
                end
            endcase
            // header completes here: load the payload counter
            if (o_res_valid && o_res.kind == KindHeader) begin
                o_res.last = len_zero;
                n_rem      = n_len;
                n_kidx     = 2'd0;
            end
        end
        o_res.fin            = (n_flags & FinBit) != 8'd0;
        o_res.rsv1           = (n_flags & Rsv1Bit) != 8'd0;
        o_res.rsv2           = (n_flags & Rsv2Bit) != 8'd0;
        o_res.rsv3           = (n_flags & Rsv3Bit) != 8'd0;
        o_res.opcode         = n_flags[3:0] & OpcodeMask[3:0];
        o_res.masked         = n_mask;
        o_res.payload_length = n_len;
        o_res.mask_key       = n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_cnt   <= 4'd0;
            r_ext8  <= 1'b0;
            r_flags <= '0;
            r_mask  <= 1'b0;
            r_len   <= '0;
            r_key   <= '0;
            r_rem   <= '0;
            r_kidx  <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_ext8  <= n_ext8;
            r_flags <= n_flags;
            r_mask  <= n_mask;
            r_len   <= n_len;
            r_key   <= n_key;
            r_rem   <= n_rem;
            r_kidx  <= n_kidx;
        end
    end

endmodule

// ===== rtl/wsd_out_reg.sv =====
module wsd_out_reg
    import wsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== rtl/websocket_frame_deframer_top.sv =====
// websocket frame deframer
// input channel: one raw stream byte per transaction on i_data_byte, with
// i_valid / o_stall. output channel: one result per transaction, o_valid /
// i_stall. header bytes give no result; once the base header, extended
// length and masking key are in, one header result (o_kind = 0) is sent,
// then one result per payload byte (o_kind = 1), with the key applied if masked.
// o_last marks the final result of a frame; an empty frame sets it on the
// header result. every result repeats the header fields of its frame.
// a byte that causes a result passes the input register, then the result
// register, before it shows on o_valid.
// throughput: one byte per cycle while i_stall holds no result, set by the
// combinational parser step between the two registers.
// reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to waiting for the first header byte of a frame.
// when i_stall holds a result, the byte in the input register waits and
// o_stall rises; a new byte is still taken while the output slot frees.
module websocket_frame_deframer_top
    import wsd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_data_byte,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_kind,
    output logic            o_fin,
    output logic            o_rsv1,
    output logic            o_rsv2,
    output logic            o_rsv3,
    output logic [3:0]      o_opcode,
    output logic            o_masked,
    output logic [LenW-1:0] o_payload_length,
    output logic [KeyW-1:0] o_mask_key,
    output logic [7:0]      o_payload_byte,
    output logic            o_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_free;
    logic       step;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign step    = r_in_valid && out_free;
    assign o_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
        end
    end

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_fin            = out_res.fin;
    assign o_rsv1           = out_res.rsv1;
    assign o_rsv2           = out_res.rsv2;
    assign o_rsv3           = out_res.rsv3;
    assign o_opcode         = out_res.opcode;
    assign o_masked         = out_res.masked;
    assign o_payload_length = out_res.payload_length;
    assign o_mask_key       = out_res.mask_key;
    assign o_payload_byte   = out_res.payload_byte;
    assign o_last           = out_res.last;

endmodule
